### rtl/bmg_pkg.sv
// ----------------------------------------------------------------------------
// bmg_pkg
// Types, stage map and fixed-point constants of the Box-Muller sampler.
// ----------------------------------------------------------------------------
package bmg_pkg;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_MEAN      = 2'd0,
      CSR_STD_DEV   = 2'd1,
      CSR_RANGE_MIN = 2'd2,
      CSR_RANGE_MAX = 2'd3
   } bmg_csr_type;

   // stage map of the pipeline (stage 0 takes the input transaction)
   localparam int LOG_STEPS   = 24;
   localparam int TAY_FIRST   = 5;
   localparam int TAY_TERMS   = 5;
   localparam int MAP_STAGE   = 20;
   localparam int DIFF_STAGE  = 25;
   localparam int W_STAGE     = 26;
   localparam int SQRT_FIRST  = 27;
   localparam int SQRT_STEPS  = 19;
   localparam int Z_STAGE     = 46;
   localparam int SCALE_STAGE = 47;
   localparam int FINAL_STAGE = 48;
   localparam int NSTAGE      = 49;

   localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
   localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [14:0] UNIT_SIGMA  = 15'd256;

   // taylor divisors n(n+1) and their reciprocals scaled by 2^32
   localparam logic [6:0] SIN_DIV [TAY_TERMS] = '{7'd6, 7'd20, 7'd42, 7'd72, 7'd110};
   localparam logic [6:0] COS_DIV [TAY_TERMS] = '{7'd2, 7'd12, 7'd30, 7'd56, 7'd90};
   localparam logic [31:0] SIN_RECIP [TAY_TERMS] = '{
      32'((64'd1 << 32) / 64'd6),  32'((64'd1 << 32) / 64'd20),
      32'((64'd1 << 32) / 64'd42), 32'((64'd1 << 32) / 64'd72),
      32'((64'd1 << 32) / 64'd110)};
   localparam logic [31:0] COS_RECIP [TAY_TERMS] = '{
      32'((64'd1 << 32) / 64'd2),  32'((64'd1 << 32) / 64'd12),
      32'((64'd1 << 32) / 64'd30), 32'((64'd1 << 32) / 64'd56),
      32'((64'd1 << 32) / 64'd90)};

   typedef struct packed {
      logic [30:0]        lm;      // log mantissa, q1.30
      logic [4:0]         lexp;
      logic [23:0]        lfrac;
      logic [33:0]        pq;
      logic [61:0]        pr;
      logic [31:0]        phase;   // turns, q.32
      logic [1:0]         quad;
      logic               swap;
      logic [29:0]        off;
      logic [29:0]        x;
      logic [29:0]        x2;
      logic [30:0]        st;      // sine term, then quotient estimate
      logic [30:0]        ct;
      logic [30:0]        sy;
      logic [30:0]        cy;
      logic signed [31:0] sacc;
      logic signed [31:0] cacc;
      logic signed [31:0] ctrig;
      logic signed [31:0] strig;
      logic [29:0]        dw;      // log difference, then -2 ln u
      logic [37:0]        xs;
      logic [20:0]        rem;
      logic [18:0]        root;
      logic [16:0]        czm;
      logic [16:0]        szm;
      logic               cneg;
      logic               sneg;
      logic [19:0]        cdm;
      logic [19:0]        sdm;
      logic [15:0]        csample;
      logic [15:0]        ssample;
      logic               crng;
      logic               srng;
   } bmg_stage_type;

   // log2 in q.24, only evaluated for constants
   function automatic logic [28:0] log2_q24(input logic [30:0] x);
      longint unsigned m;
      logic [4:0]      e;
      logic [23:0]     f;
      e = 5'd0;
      f = 24'd0;
      for (int b = 0; b < 31; b++) begin
         if (x[b]) begin
            e = 5'(b);
         end
      end
      m = 64'(x) << (5'd30 - e);
      for (int k = 0; k < LOG_STEPS; k++) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            f = {f[22:0], 1'b1};
         end else begin
            f = {f[22:0], 1'b0};
         end
      end
      return {e, f};
   endfunction

endpackage

### rtl/box_muller_gaussian_sampler_core.sv
// ----------------------------------------------------------------------------
// box_muller_gaussian_sampler_core
// Fixed-point Box-Muller transform: two uniform words in, two gaussian
// samples out, with a range flag on each.
// ----------------------------------------------------------------------------
// One input transaction may enter every clock while the pipeline is not
// stalled by the output; a pair with a zero word is taken and dropped. Each
// kept pair gives two results, the cosine sample first (rsp_last low) and
// the sine sample second, so the sustained rate is set by the single result
// port. The accepting edge loads the pair into the first stage of a 49-stage
// pipeline (24 squaring stages of the logarithm, then 19 stages of the
// square root, with the phase and taylor series running alongside), from
// whose last stage the cosine result passes to the output register. Mean,
// deviation and limits are applied in the last stages, so configuration
// writes must be made while no transaction is in flight.
module box_muller_gaussian_sampler_core #(
   parameter int UNIFORM_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [UNIFORM_BITS-1:0] req_uniform_u,
   input  logic [UNIFORM_BITS-1:0] req_uniform_v,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [15:0]      rsp_sample,
   output logic                    rsp_in_range,
   output logic                    rsp_last,
   input  logic                    csr_write_en,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_wdata
);
   import bmg_pkg::*;

   localparam logic [63:0] DMAX_W = (64'd1 << UNIFORM_BITS) - 64'd1;
   localparam logic [63:0] PH_Q_W = (64'd1 << 32) / DMAX_W;
   localparam logic [63:0] PH_R_W = (64'd1 << 32) - PH_Q_W * DMAX_W;
   localparam logic [30:0] DMAX   = DMAX_W[30:0];
   localparam logic [25:0] PH_Q   = PH_Q_W[25:0];
   localparam logic [30:0] PH_R   = PH_R_W[30:0];
   localparam logic [28:0] LOG_D  = log2_q24(DMAX);

   logic signed [15:0] mean_ff;
   logic [14:0]        std_dev_ff;
   logic signed [15:0] range_min_ff;
   logic signed [15:0] range_max_ff;

   bmg_stage_type stage_ff [NSTAGE];
   bmg_stage_type stage_in [NSTAGE];
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;

   logic               out_valid_ff;
   logic               out_sel_ff;
   logic signed [15:0] out_cs_ff;
   logic signed [15:0] out_ss_ff;
   logic               out_cr_ff;
   logic               out_sr_ff;

   logic        out_free;
   logic        adv;
   logic [14:0] sigma;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff      <= 16'sd0;
         std_dev_ff   <= UNIT_SIGMA;
         range_min_ff <= -16'sd768;
         range_max_ff <= 16'sd768;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MEAN:      mean_ff      <= csr_wdata;
            CSR_STD_DEV:   std_dev_ff   <= csr_wdata[14:0];
            CSR_RANGE_MIN: range_min_ff <= csr_wdata;
            CSR_RANGE_MAX: range_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign sigma = (std_dev_ff == 15'd0) ? UNIT_SIGMA : std_dev_ff;

   // the pipeline moves when its last stage drains or holds nothing
   assign out_free  = !out_valid_ff || (out_sel_ff && rsp_ready);
   assign adv       = out_free || !vld_ff[NSTAGE-1];
   assign req_ready = adv;

   always_comb begin
      vld_in[0] = req_valid && (req_uniform_u != '0) && (req_uniform_v != '0);
      for (int i = 1; i < NSTAGE; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   always_comb begin
      bmg_stage_type      nx;
      logic [30:0]        u_ext;
      logic [30:0]        v_ext;
      logic [4:0]         e;
      logic [61:0]        sqm;
      logic [31:0]        sqt;
      logic [30:0]        hi;
      logic [30:0]        lo;
      logic [31:0]        hs;
      logic [1:0]         corr;
      logic [62:0]        prod63;
      logic [59:0]        prod60;
      logic [60:0]        prod61;
      logic [37:0]        qc;
      logic [37:0]        rr;
      logic [30:0]        qe;
      logic signed [31:0] sv;
      logic signed [31:0] cv;
      logic [28:0]        lu;
      logic [22:0]        remn;
      logic [20:0]        trial;
      logic [30:0]        cmag;
      logic [30:0]        smag;
      logic [49:0]        zp;
      logic [31:0]        dp;
      logic signed [21:0] sum;

      sqm    = '0;
      sqt    = '0;
      hi     = '0;
      lo     = '0;
      hs     = '0;
      corr   = '0;
      prod63 = '0;
      prod60 = '0;
      prod61 = '0;
      qc     = '0;
      rr     = '0;
      qe     = '0;
      sv     = '0;
      cv     = '0;
      lu     = '0;
      remn   = '0;
      trial  = '0;
      cmag   = '0;
      smag   = '0;
      zp     = '0;
      dp     = '0;
      sum    = '0;

      // stage 0: normalise u, start the phase division
      nx = '0;
      u_ext = 31'(req_uniform_u);
      v_ext = 31'(req_uniform_v);
      e = 5'd0;
      for (int b = 0; b < 31; b++) begin
         if (u_ext[b]) begin
            e = 5'(b);
         end
      end
      nx.lm   = 31'(u_ext << (5'd30 - e));
      nx.lexp = e;
      nx.pq   = 34'(v_ext * PH_Q);
      nx.pr   = 62'(v_ext * PH_R);
      stage_in[0] = nx;

      for (int i = 1; i < NSTAGE; i++) begin
         nx = stage_ff[i-1];
         // log2 mantissa squaring, one fraction bit per stage
         if (i <= LOG_STEPS) begin
            sqm = 62'(nx.lm) * 62'(nx.lm);
            sqt = sqm[61:30];
            if (sqt[31]) begin
               nx.lm    = sqt[31:1];
               nx.lfrac = {nx.lfrac[22:0], 1'b1};
            end else begin
               nx.lm    = sqt[30:0];
               nx.lfrac = {nx.lfrac[22:0], 1'b0};
            end
         end
         // v * 2^32 / (2^B - 1), using 2^B = 1 modulo the divisor
         if (i == 1) begin
            hi = 31'(nx.pr >> UNIFORM_BITS);
            lo = nx.pr[30:0] & DMAX;
            hs = 32'(hi) + 32'(lo);
            if (hs >= {DMAX, 1'b0}) begin
               corr = 2'd2;
            end else if (hs >= 32'(DMAX)) begin
               corr = 2'd1;
            end else begin
               corr = 2'd0;
            end
            nx.phase = 32'(nx.pq + 34'(hi) + 34'(corr));
         end
         // fold the phase into the first octant
         if (i == 2) begin
            nx.quad = nx.phase[31:30];
            nx.swap = nx.phase[29];
            if (nx.phase[29]) begin
               nx.off = 30'(ONE_Q30 - {1'b0, nx.phase[29:0]});
            end else begin
               nx.off = nx.phase[29:0];
            end
         end
         if (i == 3) begin
            prod63 = 63'(nx.off) * 63'(TWO_PI_Q30);
            nx.x   = 30'((prod63 + 63'h8000_0000) >> 32);
         end
         if (i == 4) begin
            prod60 = 60'(nx.x) * 60'(nx.x);
            nx.x2   = prod60[59:30];
            nx.st   = 31'(nx.x);
            nx.ct   = ONE_Q30;
            nx.sacc = 32'(nx.x);
            nx.cacc = 32'(ONE_Q30);
         end
         // taylor terms: multiply, reciprocal estimate, correct and add
         for (int k = 0; k < TAY_TERMS; k++) begin
            if (i == TAY_FIRST + 3 * k) begin
               prod61 = 61'(nx.st) * 61'(nx.x2);
               nx.sy  = prod61[60:30];
               prod61 = 61'(nx.ct) * 61'(nx.x2);
               nx.cy  = prod61[60:30];
            end
            if (i == TAY_FIRST + 3 * k + 1) begin
               prod63 = 63'(nx.sy) * 63'(SIN_RECIP[k]);
               nx.st  = prod63[62:32];
               prod63 = 63'(nx.cy) * 63'(COS_RECIP[k]);
               nx.ct  = prod63[62:32];
            end
            if (i == TAY_FIRST + 3 * k + 2) begin
               qc = 38'(nx.st) * 38'(SIN_DIV[k]);
               rr = 38'(nx.sy) - qc;
               qe = (rr >= 38'(SIN_DIV[k])) ? nx.st + 31'd1 : nx.st;
               nx.st = qe;
               if (k % 2 == 0) begin
                  nx.sacc = nx.sacc - 32'(qe);
               end else begin
                  nx.sacc = nx.sacc + 32'(qe);
               end
               qc = 38'(nx.ct) * 38'(COS_DIV[k]);
               rr = 38'(nx.cy) - qc;
               qe = (rr >= 38'(COS_DIV[k])) ? nx.ct + 31'd1 : nx.ct;
               nx.ct = qe;
               if (k % 2 == 0) begin
                  nx.cacc = nx.cacc - 32'(qe);
               end else begin
                  nx.cacc = nx.cacc + 32'(qe);
               end
            end
         end
         // undo the octant fold, then rotate by quadrant
         if (i == MAP_STAGE) begin
            sv = nx.swap ? nx.cacc : nx.sacc;
            cv = nx.swap ? nx.sacc : nx.cacc;
            case (nx.quad)
               2'd0: begin
                  nx.ctrig = cv;
                  nx.strig = sv;
               end
               2'd1: begin
                  nx.ctrig = -sv;
                  nx.strig = cv;
               end
               2'd2: begin
                  nx.ctrig = -cv;
                  nx.strig = -sv;
               end
               default: begin
                  nx.ctrig = sv;
                  nx.strig = -cv;
               end
            endcase
         end
         if (i == DIFF_STAGE) begin
            lu = {nx.lexp, nx.lfrac};
            nx.dw = (LOG_D > lu) ? 30'(LOG_D - lu) : 30'd0;
         end
         if (i == W_STAGE) begin
            prod60  = 60'(nx.dw[28:0]) * 60'(TWO_LN2_Q30);
            nx.dw   = 30'((prod60 + 60'h2000_0000) >> 30);
            nx.xs   = {nx.dw, 8'd0};
            nx.rem  = 21'd0;
            nx.root = 19'd0;
         end
         // restoring square root, one root bit per stage
         if (i >= SQRT_FIRST && i < SQRT_FIRST + SQRT_STEPS) begin
            remn  = {nx.rem, nx.xs[37:36]};
            trial = {nx.root[18:0], 2'b01};
            if (remn >= 23'(trial)) begin
               nx.rem  = 21'(remn - 23'(trial));
               nx.root = {nx.root[17:0], 1'b1};
            end else begin
               nx.rem  = remn[20:0];
               nx.root = {nx.root[17:0], 1'b0};
            end
            nx.xs = {nx.xs[35:0], 2'b00};
         end
         if (i == Z_STAGE) begin
            cmag    = nx.ctrig[31] ? 31'(-nx.ctrig) : nx.ctrig[30:0];
            smag    = nx.strig[31] ? 31'(-nx.strig) : nx.strig[30:0];
            nx.cneg = nx.ctrig[31];
            nx.sneg = nx.strig[31];
            zp      = 50'(nx.root) * 50'(cmag);
            nx.czm  = 17'((zp + 50'h2_0000_0000) >> 34);
            zp      = 50'(nx.root) * 50'(smag);
            nx.szm  = 17'((zp + 50'h2_0000_0000) >> 34);
         end
         if (i == SCALE_STAGE) begin
            dp     = 32'(nx.czm) * 32'(sigma);
            nx.cdm = 20'((dp + 32'd2048) >> 12);
            dp     = 32'(nx.szm) * 32'(sigma);
            nx.sdm = 20'((dp + 32'd2048) >> 12);
         end
         // add the mean, saturate, compare with the limits
         if (i == FINAL_STAGE) begin
            sum = nx.cneg ? {{6{mean_ff[15]}}, mean_ff} - {2'b00, nx.cdm}
                          : {{6{mean_ff[15]}}, mean_ff} + {2'b00, nx.cdm};
            if (sum > 22'sd32767) begin
               nx.csample = 16'h7FFF;
            end else if (sum < -22'sd32768) begin
               nx.csample = 16'h8000;
            end else begin
               nx.csample = sum[15:0];
            end
            nx.crng = ($signed(nx.csample) >= range_min_ff) &&
                      ($signed(nx.csample) <= range_max_ff);
            sum = nx.sneg ? {{6{mean_ff[15]}}, mean_ff} - {2'b00, nx.sdm}
                          : {{6{mean_ff[15]}}, mean_ff} + {2'b00, nx.sdm};
            if (sum > 22'sd32767) begin
               nx.ssample = 16'h7FFF;
            end else if (sum < -22'sd32768) begin
               nx.ssample = 16'h8000;
            end else begin
               nx.ssample = sum[15:0];
            end
            nx.srng = ($signed(nx.ssample) >= range_min_ff) &&
                      ($signed(nx.ssample) <= range_max_ff);
         end
         stage_in[i] = nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NSTAGE; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   // output register: cosine transaction first, then sine
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_sel_ff   <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= vld_ff[NSTAGE-1];
         out_sel_ff   <= 1'b0;
      end else if (rsp_ready) begin
         out_sel_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_cs_ff <= stage_ff[NSTAGE-1].csample;
         out_ss_ff <= stage_ff[NSTAGE-1].ssample;
         out_cr_ff <= stage_ff[NSTAGE-1].crng;
         out_sr_ff <= stage_ff[NSTAGE-1].srng;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_last     = out_sel_ff;
   assign rsp_sample   = out_sel_ff ? out_ss_ff : out_cs_ff;
   assign rsp_in_range = out_sel_ff ? out_sr_ff : out_cr_ff;

`ifndef NO_ASSERTIONS
   // a taken cosine transaction is always followed by its sine partner
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last)
      else $error("sine sample missing after cosine");

   // no two sine transactions in a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !(rsp_valid && rsp_last))
      else $error("sine sample repeated");

   // an empty output register never stalls the input
   assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("input stalled with free output");

   // a pair with a zero word never enters the pipeline as valid
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_uniform_u == '0 || req_uniform_v == '0)
      |=> !vld_ff[0])
      else $error("zero word pair entered pipeline");
`endif

endmodule
